// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rgb pwm design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds on every clock edge out of reset
`define RGBPWM_ASSERT(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("rgbpwm assertion failed");

// consequent in the same cycle
`define RGBPWM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgbpwm implication failed");

// consequent in the next cycle
`define RGBPWM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgbpwm next-cycle implication failed");

`endif

// ===== hdl/rgbpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbpwm_pkg
// Types and constants of the three-channel rgb pwm generator.
// ----------------------------------------------------------------------------
package rgbpwm_pkg;

  localparam int unsigned NUM_CH = 3;

  localparam logic [6:0] BRIGHT_MAX = 7'd100;
  localparam logic [6:0] CNT_MAX    = 7'd127;

  typedef enum logic [2:0] {
    REG_RED    = 3'd0,
    REG_GREEN  = 3'd1,
    REG_BLUE   = 3'd2,
    REG_BRIGHT = 3'd3,
    REG_ENABLE = 3'd4
  } cfg_reg_e;

  typedef logic [6:0] duty_t;

  typedef struct packed {
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [6:0] brightness;
    logic       output_enable;
  } cfg_t;

  typedef struct packed {
    logic  step;
    duty_t duty;
  } chan_ctrl_t;

  // floor(x / 255) for x up to 100 * 255
  function automatic logic [6:0] div255(input logic [14:0] x);
    logic [15:0] s;
    s = {1'b0, x} + 16'(x[14:8]) + 16'd1;
    return s[14:8];
  endfunction

endpackage

// ===== hdl/rgbpwm_if.sv =====
// ----------------------------------------------------------------------------
// rgbpwm interfaces
// Valid/ready channels for ticks, pin results and register writes.
// ----------------------------------------------------------------------------
interface rgbpwm_tick_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface rgbpwm_pin_if;
  logic valid;
  logic ready;
  logic red_pin;
  logic green_pin;
  logic blue_pin;

  modport source (output valid, output red_pin, output green_pin, output blue_pin,
                  input ready);
  modport sink (input valid, input red_pin, input green_pin, input blue_pin,
                output ready);
endinterface

interface rgbpwm_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/rgb_three_channel_pwm_core.sv =====
// a tick item is registered in the input register, and its pin item is then registered in
// the pin result registers; a stall on the pin side can hold the item in between
// throughput: one tick item per cycle without pin stalls; one compare and update per channel
// an input register and the pin result registers part the two sides
// reset: levels 0, brightness 100, output disabled, all channels in high phase,
// all pins high, no item held
// ----------------------------------------------------------------------------
// rgb_three_channel_pwm_core
// Three-channel rgb pwm generator, one pwm step per tick item whose tick bit is set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_three_channel_pwm_core #(
  parameter int unsigned PERIOD_TICKS = 100
) (
  input logic          clk_i,
  input logic          rst_ni,
  rgbpwm_tick_if.sink  tick_i,
  rgbpwm_cfg_if.sink   cfg_i,
  rgbpwm_pin_if.source pin_o
);
  import rgbpwm_pkg::*;

  cfg_t       cfg_q;
  logic       s1_valid_q, s1_tick_q;
  logic       out_valid_q;
  logic       s2_adv;
  logic       in_ready;
  duty_t      duty [NUM_CH];
  logic       pins [NUM_CH];
  chan_ctrl_t ctrl [NUM_CH];

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_level     <= 8'd0;
      cfg_q.green_level   <= 8'd0;
      cfg_q.blue_level    <= 8'd0;
      cfg_q.brightness    <= BRIGHT_MAX;
      cfg_q.output_enable <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_RED:    cfg_q.red_level     <= cfg_i.data;
        REG_GREEN:  cfg_q.green_level   <= cfg_i.data;
        REG_BLUE:   cfg_q.blue_level    <= cfg_i.data;
        REG_BRIGHT: cfg_q.brightness    <= cfg_i.data[6:0];
        REG_ENABLE: cfg_q.output_enable <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // item flow
  assign s2_adv       = !out_valid_q || pin_o.ready;
  assign in_ready     = !s1_valid_q || s2_adv;
  assign tick_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= tick_i.valid;
      end
      if (s2_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && tick_i.valid) begin
      s1_tick_q <= tick_i.tick;
    end
  end

  rgbpwm_duty #(
    .PERIOD_TICKS(PERIOD_TICKS)
  ) u_duty (
    .cfg_i (cfg_q),
    .duty_o(duty)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    assign ctrl[c].step = s1_valid_q && s2_adv && s1_tick_q;
    assign ctrl[c].duty = duty[c];

    rgbpwm_chan #(
      .PERIOD_TICKS(PERIOD_TICKS)
    ) u_chan (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl[c]),
      .pin_o (pins[c])
    );
  end

  assign pin_o.valid     = out_valid_q;
  assign pin_o.red_pin   = pins[0];
  assign pin_o.green_pin = pins[1];
  assign pin_o.blue_pin  = pins[2];

  `RGBPWM_ASSERT_NEXT(a_accept_fills_s1, tick_i.valid && in_ready, s1_valid_q)
  `RGBPWM_ASSERT_IMPL(a_full_blocks_input, s1_valid_q && out_valid_q && !pin_o.ready,
                      !in_ready)
  `RGBPWM_ASSERT_NEXT(a_s1_moves_to_out, s1_valid_q && s2_adv, out_valid_q)

endmodule

// ===== hdl/rgbpwm_duty.sv =====
// ----------------------------------------------------------------------------
// rgbpwm_duty
// Per-channel duty from level and brightness, saturated to the period, zero while output is disabled.
// ----------------------------------------------------------------------------
module rgbpwm_duty #(
  parameter int unsigned PERIOD_TICKS = 100
) (
  input  rgbpwm_pkg::cfg_t  cfg_i,
  output rgbpwm_pkg::duty_t duty_o [rgbpwm_pkg::NUM_CH]
);
  import rgbpwm_pkg::*;

  localparam logic [6:0] PERIOD = 7'(PERIOD_TICKS);

  logic [6:0] bright_sat;
  logic [7:0] level [NUM_CH];

  assign bright_sat = (cfg_i.brightness > BRIGHT_MAX) ? BRIGHT_MAX : cfg_i.brightness;
  assign level[0]   = cfg_i.red_level;
  assign level[1]   = cfg_i.green_level;
  assign level[2]   = cfg_i.blue_level;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic [14:0] prod;
    logic [6:0]  quot;

    assign prod = 15'(level[c]) * 15'(bright_sat);
    assign quot = div255(prod);

    always_comb begin
      if (!cfg_i.output_enable) begin
        duty_o[c] = 7'd0;
      end else if (quot > PERIOD) begin
        duty_o[c] = PERIOD;
      end else begin
        duty_o[c] = quot;
      end
    end
  end

endmodule

// ===== hdl/rgbpwm_chan.sv =====
// ----------------------------------------------------------------------------
// rgbpwm_chan
// One pwm channel: phase counter, low-phase length and pin level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgbpwm_chan #(
  parameter int unsigned PERIOD_TICKS = 100
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rgbpwm_pkg::chan_ctrl_t ctrl_i,
  output logic                   pin_o
);
  import rgbpwm_pkg::*;

  localparam logic [6:0] PERIOD = 7'(PERIOD_TICKS);

  logic       phase_low_q, phase_low_d;
  logic [6:0] count_q, count_d;
  logic [6:0] low_len_q, low_len_d;
  logic       pin_q, pin_d;
  logic [6:0] count_inc;

  assign count_inc = (count_q == CNT_MAX) ? CNT_MAX : count_q + 7'd1;

  always_comb begin
    phase_low_d = phase_low_q;
    count_d     = count_q;
    low_len_d   = low_len_q;
    pin_d       = pin_q;
    if (ctrl_i.step) begin
      count_d = count_inc;
      if (!phase_low_q) begin
        if (count_inc >= ctrl_i.duty) begin
          if (ctrl_i.duty != PERIOD) begin
            pin_d = 1'b0;
          end
          count_d     = 7'd0;
          low_len_d   = PERIOD - ctrl_i.duty;
          phase_low_d = 1'b1;
        end
      end else begin
        if (count_inc >= low_len_q) begin
          if (low_len_q != PERIOD) begin
            pin_d = 1'b1;
          end
          count_d     = 7'd0;
          phase_low_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_low_q <= 1'b0;
      count_q     <= 7'd0;
      low_len_q   <= 7'd0;
      pin_q       <= 1'b1;
    end else begin
      phase_low_q <= phase_low_d;
      count_q     <= count_d;
      low_len_q   <= low_len_d;
      pin_q       <= pin_d;
    end
  end

  assign pin_o = pin_q;

  `RGBPWM_ASSERT(a_low_len_in_period, low_len_q <= PERIOD)
  `RGBPWM_ASSERT_NEXT(a_hold_without_step, !ctrl_i.step, $stable(pin_q) && $stable(count_q))
  `RGBPWM_ASSERT_IMPL(a_pin_moves_with_phase, pin_q != $past(pin_q),
                      phase_low_q != $past(phase_low_q))

endmodule
